// ----- rtl/core/tgs_pkg.sv -----
// Shared types and constants of the tiled gradient sum block.
package tgs_pkg;

    localparam int INNER_MAX   = 1024;
    localparam int MAX_TILES   = 4;
    localparam int EW          = $clog2(INNER_MAX);
    localparam int TW          = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QW          = $clog2(QUEUE_DEPTH);

    localparam int ACC_W = 34;
    localparam int SUM_W = 20;

    localparam logic signed [15:0] WEIGHT_ONE = 16'sd16384;

    typedef enum logic [2:0] {
        CFG_TILE_COUNT  = 3'd0,
        CFG_INNER_SIZE  = 3'd1,
        CFG_USE_COEFF   = 3'd2,
        CFG_GRAD_ENABLE = 3'd3,
        CFG_COEFF_0     = 3'd4,
        CFG_COEFF_1     = 3'd5,
        CFG_COEFF_2     = 3'd6,
        CFG_COEFF_3     = 3'd7
    } t_cfg_index;

    // One classified sample on its way from front to back.
    typedef struct packed {
        logic signed [15:0] grad;
        logic signed [15:0] weight;
        logic [EW-1:0]      addr;
        logic               first_tile;
        logic               last_tile;
        logic               last_elem;
    } t_item;

endpackage

// ----- rtl/core/tiled_gradient_sum.sv -----
// Tiled gradient sum: weighted accumulation of tile-major gradient samples.
//
// Input channel: i_grad_value with i_in_valid / o_in_stall; a sample is taken
// on a rising edge with valid high and stall low. Output channel: o_grad_sum
// and o_block_end with o_out_valid / i_out_stall, taken the same way.
// Configuration: write i_cfg_data to register i_cfg_index on any edge with
// i_cfg_we high, only while the block is idle.
// One sample per cycle is accepted in steady state. A sample of the last tile
// passes through the queue, then multiply and memory read, then accumulate and
// round into the result register; other tiles and disabled samples yield
// nothing. The rate is set by the partial-sum memory, read at one address and
// written at another in the same cycle, with the sum of one element forwarded
// to a following access of the same element.
// When the receiver stalls, the result register holds and the back end stops;
// the four-entry queue keeps taking samples until it fills, then o_in_stall
// rises. Reset restores the configuration defaults and clears the counters,
// queue and pipeline; the partial-sum memory is not cleared, since the first
// tile of each block overwrites it.
module tiled_gradient_sum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [15:0]  i_grad_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [19:0]  o_grad_sum,
    output logic                o_block_end
);
    import tgs_pkg::*;

    logic  accept;
    logic  push;
    t_item f_item;
    logic  q_valid;
    t_item q_item;
    logic  q_full;
    logic  pop;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    tgs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_grad_value (i_grad_value),
        .o_push       (push),
        .o_item       (f_item)
    );

    tgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_full  (q_full)
    );

    tgs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_grad_sum  (o_grad_sum),
        .o_block_end (o_block_end)
    );

endmodule

// ----- rtl/core/tgs_front.sv -----
// Front end: configuration registers, tile and element counters, item classification.
module tgs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_accept,
    input  logic signed [15:0]   i_grad_value,
    output logic                 o_push,
    output tgs_pkg::t_item       o_item
);
    import tgs_pkg::*;

    logic [2:0]         r_tile_count;
    logic [10:0]        r_inner_size;
    logic               r_use_coeff;
    logic               r_grad_enable;
    logic signed [15:0] r_coeff [MAX_TILES];
    logic [EW-1:0]      r_elem;
    logic [TW-1:0]      r_tile;

    logic [2:0]    tiles;
    logic [2:0]    tiles_m1;
    logic [10:0]   inner;
    logic [10:0]   inner_m1;
    logic [EW-1:0] e;
    logic [TW-1:0] t;
    logic          last_elem;
    logic          last_tile;
    logic [EW-1:0] n_elem;
    logic [TW-1:0] n_tile;

    always_comb begin
        if (r_tile_count == 3'd0) begin
            tiles = 3'd1;
        end else if (r_tile_count > 3'(MAX_TILES)) begin
            tiles = 3'(MAX_TILES);
        end else begin
            tiles = r_tile_count;
        end
        if (r_inner_size == 11'd0) begin
            inner = 11'd1;
        end else if (r_inner_size > 11'(INNER_MAX)) begin
            inner = 11'(INNER_MAX);
        end else begin
            inner = r_inner_size;
        end
        tiles_m1 = tiles - 3'd1;
        inner_m1 = inner - 11'd1;

        // Indices beyond a shrunk size count as the last position
        e = ({1'b0, r_elem} >= inner) ? inner_m1[EW-1:0] : r_elem;
        t = ({1'b0, r_tile} >= tiles) ? tiles_m1[TW-1:0] : r_tile;
        last_elem = (e == inner_m1[EW-1:0]);
        last_tile = (t == tiles_m1[TW-1:0]);

        if (last_elem) begin
            n_elem = '0;
            n_tile = last_tile ? '0 : t + TW'(1);
        end else begin
            n_elem = e + EW'(1);
            n_tile = t;
        end

        o_item.grad       = i_grad_value;
        o_item.weight     = r_use_coeff ? r_coeff[t] : WEIGHT_ONE;
        o_item.addr       = e;
        o_item.first_tile = (t == '0);
        o_item.last_tile  = last_tile;
        o_item.last_elem  = last_elem;
        o_push            = i_accept && r_grad_enable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_count  <= 3'd1;
            r_inner_size  <= 11'd1;
            r_use_coeff   <= 1'b0;
            r_grad_enable <= 1'b1;
            for (int i = 0; i < MAX_TILES; i++) begin
                r_coeff[i] <= WEIGHT_ONE;
            end
            r_elem <= '0;
            r_tile <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_TILE_COUNT:  r_tile_count  <= i_cfg_data[2:0];
                    CFG_INNER_SIZE:  r_inner_size  <= i_cfg_data[10:0];
                    CFG_USE_COEFF:   r_use_coeff   <= i_cfg_data[0];
                    CFG_GRAD_ENABLE: r_grad_enable <= i_cfg_data[0];
                    CFG_COEFF_0:     r_coeff[0]    <= i_cfg_data;
                    CFG_COEFF_1:     r_coeff[1]    <= i_cfg_data;
                    CFG_COEFF_2:     r_coeff[2]    <= i_cfg_data;
                    CFG_COEFF_3:     r_coeff[3]    <= i_cfg_data;
                    default: ;
                endcase
            end
            // Disabled transactions leave the counters alone
            if (o_push) begin
                r_elem <= n_elem;
                r_tile <= n_tile;
            end
        end
    end

endmodule

// ----- rtl/core/tgs_queue.sv -----
// Short item queue between front and back.
module tgs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tgs_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_valid,
    output tgs_pkg::t_item o_item,
    output logic           o_full
);
    import tgs_pkg::*;

    t_item       r_mem [QUEUE_DEPTH];
    logic [QW-1:0] r_wr_ptr;
    logic [QW-1:0] r_rd_ptr;
    logic [QW:0]   r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (QW+1)'(QUEUE_DEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QW+1)'(1);
                2'b01:   r_count <= r_count - (QW+1)'(1);
                default: ;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue popped while empty");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == $past(r_count) + 1)
        || (r_count == $past(r_count) - 1))
        else $error("queue count jumped");

endmodule

// ----- rtl/core/tgs_back.sv -----
// Back end: multiply, partial-sum memory read-modify-write, rounding and result register.
module tgs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  tgs_pkg::t_item      i_q_item,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [19:0]  o_grad_sum,
    output logic                o_block_end
);
    import tgs_pkg::*;

    logic signed [ACC_W-1:0] r_mem [INNER_MAX];
    logic signed [ACC_W-1:0] r_rd_data;
    logic signed [ACC_W-1:0] r_last_sum;

    logic               r_a_valid;
    logic signed [31:0] r_a_prod;
    logic [EW-1:0]      r_a_addr;
    logic               r_a_first;
    logic               r_a_last_tile;
    logic               r_a_last_elem;
    logic               r_a_fwd;

    logic               r_out_valid;
    logic signed [19:0] r_out_sum;
    logic               r_out_end;

    logic                    adv;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W:0]   rnd;
    logic signed [20:0]      q;
    logic signed [19:0]      sat;

    // Whole pipeline moves together; it holds only while a result is stalled
    assign adv   = !r_out_valid || !i_out_stall;
    assign o_pop = i_q_valid && adv;

    always_comb begin
        base = r_a_fwd ? r_last_sum : r_rd_data;
        sum  = r_a_first ? ACC_W'(r_a_prod) : base + ACC_W'(r_a_prod);
        // Round to nearest, ties upward, then drop the 14 fraction bits
        rnd  = (ACC_W+1)'(sum) + (ACC_W+1)'(8192);
        q    = rnd[34:14];
        if (q > 21'sd524287) begin
            sat = 20'sd524287;
        end else if (q < -21'sd524288) begin
            sat = -20'sd524288;
        end else begin
            sat = q[19:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_a_valid) begin
            r_mem[r_a_addr] <= sum;
            r_last_sum      <= sum;
        end
        if (o_pop) begin
            r_rd_data     <= r_mem[i_q_item.addr];
            r_a_prod      <= i_q_item.grad * i_q_item.weight;
            r_a_addr      <= i_q_item.addr;
            r_a_first     <= i_q_item.first_tile;
            r_a_last_tile <= i_q_item.last_tile;
            r_a_last_elem <= i_q_item.last_elem;
            // Read sees the old entry when the item ahead writes it on the same edge
            r_a_fwd       <= r_a_valid && (r_a_addr == i_q_item.addr);
        end
        if (adv) begin
            r_out_sum <= sat;
            r_out_end <= r_a_last_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid   <= i_q_valid;
            r_out_valid <= r_a_valid && r_a_last_tile;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_grad_sum  = r_out_sum;
    assign o_block_end = r_out_end;

    a_fwd_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_a_valid && (r_a_addr == i_q_item.addr)) |=> r_a_fwd)
        else $error("same-address item not forwarded");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_a_valid) && $stable(r_a_addr)))
        else $error("stage moved while result stalled");

    a_result_from_last_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_a_valid && r_a_last_tile) |=> o_out_valid)
        else $error("last-tile item gave no result");

endmodule

// ----- verif/tb_tiled_gradient_sum.sv -----
// Self-checking testbench for the tiled gradient sum block: directed and random sample streams.
`timescale 1ns / 1ps

module tb_tiled_gradient_sum;
    import tgs_pkg::*;

    localparam int IDLE_PCT       = 11;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1925;
    localparam longint SUM_MAX    = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint SUM_MIN    = -(longint'(1) << (SUM_W - 1));

    typedef struct {
        logic signed [SUM_W-1:0] sum;
        logic                    block_end;
    } t_grad_result;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_cfg_we     = 1'b0;
    logic [2:0]              i_cfg_index  = '0;
    logic [15:0]             i_cfg_data   = '0;
    logic                    i_in_valid   = 1'b0;
    logic signed [15:0]      i_grad_value = '0;
    logic                    i_out_stall  = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic signed [SUM_W-1:0] o_grad_sum;
    logic                    o_block_end;

    // Shadow of the block's registers and accumulation state
    logic [2:0]              reg_tiles     = 3'd1;
    logic [10:0]             reg_inner     = 11'd1;
    logic                    reg_use_coeff = 1'b0;
    logic                    reg_enable    = 1'b1;
    logic signed [15:0]      reg_coeff [MAX_TILES] = '{default: WEIGHT_ONE};
    logic signed [ACC_W-1:0] tile_acc [INNER_MAX];
    logic [EW-1:0]           elem_ptr = '0;
    logic [TW-1:0]           tile_ptr = '0;

    logic signed [15:0] grad_backlog [$];
    t_grad_result       expected_sums [$];
    t_grad_result       oldest;

    int   mismatch_count = 0;
    int   quiet_cycles   = 0;
    int   hold_count     = 0;
    logic hold_arm       = 1'b0;
    logic hold_done      = 1'b0;
    logic calm           = 1'b0;

    tiled_gradient_sum u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_grad_value (i_grad_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_grad_sum   (o_grad_sum),
        .o_block_end  (o_block_end)
    );

    always #5 i_clk = ~i_clk;

    function automatic int eff_tiles(input logic [2:0] v);
        if (v == 0) return 1;
        if (v > MAX_TILES) return MAX_TILES;
        return int'(v);
    endfunction

    function automatic int eff_inner(input logic [10:0] v);
        if (v == 0) return 1;
        if (v > INNER_MAX) return INNER_MAX;
        return int'(v);
    endfunction

    function automatic logic signed [15:0] rand_q16();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Weight one sample, fold it into its element's sum and queue the finished sum
    function automatic void accumulate_sample(input logic signed [15:0] grad);
        int                      tiles;
        int                      inner;
        int                      e;
        int                      t;
        logic signed [15:0]      weight;
        logic signed [ACC_W-1:0] prod;
        logic signed [ACC_W-1:0] biased;
        logic signed [ACC_W-1:0] rounded;
        t_grad_result            res;
        if (!reg_enable) return;
        tiles  = eff_tiles(reg_tiles);
        inner  = eff_inner(reg_inner);
        e      = (elem_ptr >= inner) ? inner - 1 : int'(elem_ptr);
        t      = (tile_ptr >= tiles) ? tiles - 1 : int'(tile_ptr);
        weight = reg_use_coeff ? reg_coeff[t] : WEIGHT_ONE;
        prod   = grad * weight;
        if (t == 0) begin
            tile_acc[e] = prod;
        end else begin
            tile_acc[e] = tile_acc[e] + prod;
        end
        if (e == inner - 1) begin
            elem_ptr = '0;
            tile_ptr = (t == tiles - 1) ? '0 : TW'(t + 1);
        end else begin
            elem_ptr = EW'(e + 1);
            tile_ptr = TW'(t);
        end
        if (t == tiles - 1) begin
            // round half up, dropping the 14 fraction bits of the Q2.14 weight, then clamp to the output width
            biased  = tile_acc[e] + 34'sd8192;
            rounded = biased >>> 14;
            if (rounded > SUM_MAX) begin
                res.sum = SUM_W'(SUM_MAX);
            end else if (rounded < SUM_MIN) begin
                res.sum = SUM_W'(SUM_MIN);
            end else begin
                res.sum = rounded[SUM_W-1:0];
            end
            res.block_end = (e == inner - 1);
            expected_sums.push_back(res);
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // Sender: offer queued samples, shadow each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) accumulate_sample(i_grad_value);
            if (!i_in_valid || !o_in_stall) begin
                if (grad_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    i_in_valid   <= 1'b1;
                    i_grad_value <= grad_backlog.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result transaction against the oldest expected sum
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_sums.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result sum=%0d end=%0b",
                                            o_grad_sum, o_block_end));
                end else begin
                    oldest = expected_sums.pop_front();
                    if (o_grad_sum !== oldest.sum)
                        flag_mismatch($sformatf("grad_sum %0d, expected %0d",
                                                o_grad_sum, oldest.sum));
                    if (o_block_end !== oldest.block_end)
                        flag_mismatch($sformatf("block_end %0b, expected %0b",
                                                o_block_end, oldest.block_end));
                end
            end
            if (hold_arm && !hold_done) begin
                if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
                hold_count <= hold_count + 1;
            end
            i_out_stall <= (hold_arm && !hold_done) ||
                           (!calm && $urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] no transaction for %0d cycles", $time, quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic cfg_write(input t_cfg_index idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_TILE_COUNT:  reg_tiles     = value[2:0];
            CFG_INNER_SIZE:  reg_inner     = value[10:0];
            CFG_USE_COEFF:   reg_use_coeff = value[0];
            CFG_GRAD_ENABLE: reg_enable    = value[0];
            default:         reg_coeff[int'(idx) - int'(CFG_COEFF_0)] = value;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every sample is taken and every sum has come, then let the pipe empty
    task automatic wait_idle();
        while (grad_backlog.size() != 0 || i_in_valid || expected_sums.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_items(input int count);
        repeat (count) grad_backlog.push_back(rand_q16());
        wait_idle();
    endtask

    // Growing the tile length past a later tile would read sums never written: finish
    // the block first in that case. Shrinking mid-block is fine.
    task automatic apply_sizes(input int tiles, input int inner);
        int cur_tiles;
        int cur_inner;
        int e;
        int t;
        cur_tiles = eff_tiles(reg_tiles);
        cur_inner = eff_inner(reg_inner);
        if (eff_inner(11'(inner)) > cur_inner && tile_ptr != 0) begin
            e = (elem_ptr >= cur_inner) ? cur_inner - 1 : int'(elem_ptr);
            t = (tile_ptr >= cur_tiles) ? cur_tiles - 1 : int'(tile_ptr);
            run_items((cur_tiles - 1 - t) * cur_inner + (cur_inner - e));
        end
        cfg_write(CFG_TILE_COUNT, 16'(tiles));
        cfg_write(CFG_INNER_SIZE, 16'(inner));
    endtask

    initial begin
        int phase;
        int k;
        int tiles;
        int inner;
        int count;
        int random_items;
        phase        = 0;
        random_items = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: single element, weight one
        grad_backlog.push_back(16'sh7FFF);
        grad_backlog.push_back(16'sh8000);
        grad_backlog.push_back(16'sh0000);
        grad_backlog.push_back(16'shFFFF);
        grad_backlog.push_back(16'sh0001);
        wait_idle();

        // Four tiles with extreme coefficients
        cfg_write(CFG_USE_COEFF, 16'd1);
        cfg_write(CFG_COEFF_0, 16'h8000);
        cfg_write(CFG_COEFF_1, 16'h7FFF);
        cfg_write(CFG_COEFF_2, 16'h4000);
        cfg_write(CFG_COEFF_3, 16'hFFFF);
        apply_sizes(4, 2);
        grad_backlog.push_back(16'sh7FFF);
        grad_backlog.push_back(16'sh8000);
        grad_backlog.push_back(16'sh8000);
        grad_backlog.push_back(16'sh7FFF);
        grad_backlog.push_back(16'sh5555);
        grad_backlog.push_back(16'shAAAA);
        grad_backlog.push_back(16'shFFFF);
        grad_backlog.push_back(16'sh0001);
        wait_idle();

        // Zero sizes behave as one
        apply_sizes(0, 0);
        grad_backlog.push_back(16'sh8000);
        grad_backlog.push_back(16'sh7FFF);
        wait_idle();

        // Shrink both sizes in the middle of a block
        cfg_write(CFG_USE_COEFF, 16'd0);
        apply_sizes(3, 3);
        run_items(4);
        apply_sizes(2, 2);
        run_items(1);

        // Disabled: samples are dropped without effect
        cfg_write(CFG_GRAD_ENABLE, 16'd0);
        run_items(3);
        cfg_write(CFG_GRAD_ENABLE, 16'd1);

        while (random_items < RANDOM_ITEMS) begin
            if (!reg_enable) cfg_write(CFG_GRAD_ENABLE, 16'd1);
            k     = $urandom_range(9);
            tiles = (k == 0) ? 0 : (k == 1) ? $urandom_range(7, 5) : $urandom_range(4, 1);
            k     = $urandom_range(9);
            inner = (k == 0) ? 0 : (k == 1) ? $urandom_range(64, 17) : $urandom_range(16, 1);
            count = $urandom_range(60, 10);
            cfg_write(CFG_USE_COEFF, 16'($urandom_range(1)));
            for (k = 0; k < MAX_TILES; k++)
                cfg_write(t_cfg_index'(int'(CFG_COEFF_0) + k), rand_q16());
            if (phase == 2) begin
                // receiver holds off while the sender keeps offering
                apply_sizes(1, inner);
                hold_arm = 1'b1;
                run_items(count);
                random_items += count;
            end else if (phase == 4) begin
                calm = 1'b1;
                apply_sizes(tiles, inner);
                run_items(150);
                calm = 1'b0;
                random_items += 150;
            end else if (phase == 5) begin
                // oversized tile length acts as the maximum; then shrink inside tile one
                apply_sizes(2, 2047);
                run_items(INNER_MAX);
                apply_sizes(2, 3);
                run_items(3);
                random_items += INNER_MAX + 3;
            end else begin
                apply_sizes(tiles, inner);
                if ($urandom_range(9) == 0) cfg_write(CFG_GRAD_ENABLE, 16'd0);
                run_items(count);
                if (reg_enable) random_items += count;
            end
            phase++;
        end
        wait_idle();

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/tgs_pkg.sv
rtl/core/tgs_front.sv
rtl/core/tgs_queue.sv
rtl/core/tgs_back.sv
rtl/core/tiled_gradient_sum.sv
verif/tb_tiled_gradient_sum.sv
